### hdl/prs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg: shared types, widths and the sine table for pixel rotation
// Holds the fixed-point widths, the configuration bundle, the beat passed
// between the rotate and place pipelines, and the Q1.14 quarter-wave table.
// ----------------------------------------------------------------------------
package prs_pkg;

   // Sizes of the pixel grid and of the trig fraction
   localparam int MAX_DIM        = 1024;
   localparam int TRIG_FRAC_BITS = 14;

   // Register widths (fixed by the register map)
   localparam int CFG_DIM_W   = 11;
   localparam int ANGLE_W     = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = CFG_DIM_W;
   localparam int COLOUR_W    = 32;

   // Derived datapath widths
   localparam int DIM_W      = $clog2(MAX_DIM);
   localparam int ADDR_W     = 2 * DIM_W;
   localparam int ROM_W      = TRIG_FRAC_BITS + 1;
   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int DELTA_W    = CFG_DIM_W + 2;
   localparam int PROD_W     = DELTA_W + TRIG_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int COORD_W    = SUM_W - TRIG_FRAC_BITS - 1;
   localparam int ROM_DEPTH  = 91;
   localparam int ROM_IDX_W  = $clog2(ROM_DEPTH);

   // Angle landmarks in degrees
   localparam int DEG_90  = 90;
   localparam int DEG_180 = 180;
   localparam int DEG_270 = 270;
   localparam int DEG_360 = 360;

   // pi scaled by 2^30, used only when building the table
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // Taylor term divisors (2n)(2n+1) for n = 1..12
   localparam int SERIES_TERMS = 12;
   localparam longint unsigned SERIES_DIV [SERIES_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_WINDOW_WIDTH,
      CSR_WINDOW_HEIGHT,
      CSR_ANGLE_DEGREES
   } csr_index_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] image_width;
      logic [CFG_DIM_W-1:0] image_height;
      logic [CFG_DIM_W-1:0] window_width;
      logic [CFG_DIM_W-1:0] window_height;
      logic [ANGLE_W-1:0]   angle_degrees;
   } cfg_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

   // Unrounded destination numerators, scaled by 2^(F+1)
   typedef struct packed {
      logic signed [SUM_W-1:0] nx;
      logic signed [SUM_W-1:0] ny;
      logic [COLOUR_W-1:0]     colour;
   } rot_beat_type;

   typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] sin_rom_type;

   // sin(k deg) for k = 0..90: Taylor series in Q2.30, then round half up
   function automatic sin_rom_type build_sin_rom();
      sin_rom_type     rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      begin
         rom = '0;
         for (int k = 0; k < ROM_DEPTH; k++) begin
            x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= SERIES_TERMS; n++) begin
               term = ((term * x2) >> 30) / SERIES_DIV[n - 1];
               if ((n & 1) == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            rom[k] = ROM_W'((longint'(sum) + (longint'(1) << (29 - TRIG_FRAC_BITS)))
                            >> (30 - TRIG_FRAC_BITS));
         end
         return rom;
      end
   endfunction

   localparam sin_rom_type SIN_ROM = build_sin_rom();

endpackage

### hdl/prs_trig.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_trig: sine and cosine of a whole-degree angle
// Folds the angle into the first quadrant and reads the quarter-wave table
// twice, once for sine and once for cosine (sine of angle plus 90).
// ----------------------------------------------------------------------------
module prs_trig (
   input  logic [prs_pkg::ANGLE_W-1:0] angle_degrees,
   output prs_pkg::trig_type           trig
);
   import prs_pkg::*;

   logic [ANGLE_W-1:0] sin_angle;
   logic [ANGLE_W:0]   cos_wide;
   logic [ANGLE_W-1:0] cos_angle;

   function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [ANGLE_W-1:0] a);
      logic [ROM_IDX_W-1:0] idx;
      logic                 neg;
      logic [ROM_W-1:0]     mag;
      begin
         if (int'(a) <= DEG_90) begin
            idx = ROM_IDX_W'(a);
            neg = 1'b0;
         end else if (int'(a) <= DEG_180) begin
            idx = ROM_IDX_W'(DEG_180 - int'(a));
            neg = 1'b0;
         end else if (int'(a) <= DEG_270) begin
            idx = ROM_IDX_W'(int'(a) - DEG_180);
            neg = 1'b1;
         end else begin
            idx = ROM_IDX_W'(DEG_360 - int'(a));
            neg = 1'b1;
         end
         mag = SIN_ROM[idx];
         if (neg) begin
            return -$signed({1'b0, mag});
         end
         return $signed({1'b0, mag});
      end
   endfunction

   // Reduce modulo 360; the register holds at most 511
   always_comb begin
      if (int'(angle_degrees) >= DEG_360) begin
         sin_angle = angle_degrees - ANGLE_W'(DEG_360);
      end else begin
         sin_angle = angle_degrees;
      end
      cos_wide = {1'b0, sin_angle} + (ANGLE_W + 1)'(DEG_90);
      if (int'(cos_wide) >= DEG_360) begin
         cos_angle = ANGLE_W'(cos_wide - (ANGLE_W + 1)'(DEG_360));
      end else begin
         cos_angle = ANGLE_W'(cos_wide);
      end
   end

   assign trig.sin_val = sin_lookup(sin_angle);
   assign trig.cos_val = sin_lookup(cos_angle);

endmodule

### hdl/prs_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_rotate: centre offset, rotation products and sums
// Three register stages: half-pixel deltas with sine/cosine, the four
// products, then the rotated numerators with the image centre added back.
// ----------------------------------------------------------------------------
module prs_rotate (
   input  logic                          clock,
   input  logic                          reset,
   input  prs_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [prs_pkg::DIM_W-1:0]     src_x,
   input  logic [prs_pkg::DIM_W-1:0]     src_y,
   input  logic [prs_pkg::COLOUR_W-1:0]  colour,
   output logic                          out_valid,
   input  logic                          out_ready,
   output prs_pkg::rot_beat_type         out_beat
);
   import prs_pkg::*;

   trig_type trig;

   // Stage 1: deltas and trig
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [DELTA_W-1:0] s1_dx_ff, s1_dx_in;
   logic signed [DELTA_W-1:0] s1_dy_ff, s1_dy_in;
   trig_type                  s1_trig_ff;
   logic [COLOUR_W-1:0]       s1_colour_ff;

   // Stage 2: products
   logic                      s2_valid_ff;
   logic signed [PROD_W-1:0]  s2_xc_ff, s2_ys_ff, s2_xs_ff, s2_yc_ff;
   logic [COLOUR_W-1:0]       s2_colour_ff;

   // Stage 3: numerators
   logic                      s3_valid_ff;
   logic signed [SUM_W-1:0]   s3_nx_ff, s3_nx_in;
   logic signed [SUM_W-1:0]   s3_ny_ff, s3_ny_in;
   logic [COLOUR_W-1:0]       s3_colour_ff;
   logic signed [SUM_W-1:0]   off_x, off_y;

   logic ready1, ready2, ready3;

   prs_trig u_trig (
      .angle_degrees (cfg.angle_degrees),
      .trig          (trig)
   );

   assign ready3   = !s3_valid_ff || out_ready;
   assign ready2   = !s2_valid_ff || ready3;
   assign ready1   = !s1_valid_ff || ready2;
   assign in_ready = ready1;

   assign s1_valid_in = in_valid;
   assign s1_dx_in    = DELTA_W'({src_x, 1'b1}) - DELTA_W'(cfg.image_width);
   assign s1_dy_in    = DELTA_W'({src_y, 1'b1}) - DELTA_W'(cfg.image_height);

   assign off_x = (SUM_W'(cfg.image_width) - SUM_W'(1)) <<< TRIG_FRAC_BITS;
   assign off_y = (SUM_W'(cfg.image_height) - SUM_W'(1)) <<< TRIG_FRAC_BITS;

   assign s3_nx_in = SUM_W'(s2_xc_ff) - SUM_W'(s2_ys_ff) + off_x;
   assign s3_ny_in = SUM_W'(s2_xs_ff) + SUM_W'(s2_yc_ff) + off_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         s1_dx_ff     <= s1_dx_in;
         s1_dy_ff     <= s1_dy_in;
         s1_trig_ff   <= trig;
         s1_colour_ff <= colour;
      end
      if (ready2 && s1_valid_ff) begin
         s2_xc_ff     <= PROD_W'(s1_dx_ff * s1_trig_ff.cos_val);
         s2_ys_ff     <= PROD_W'(s1_dy_ff * s1_trig_ff.sin_val);
         s2_xs_ff     <= PROD_W'(s1_dx_ff * s1_trig_ff.sin_val);
         s2_yc_ff     <= PROD_W'(s1_dy_ff * s1_trig_ff.cos_val);
         s2_colour_ff <= s1_colour_ff;
      end
      if (ready3 && s2_valid_ff) begin
         s3_nx_ff     <= s3_nx_in;
         s3_ny_ff     <= s3_ny_in;
         s3_colour_ff <= s2_colour_ff;
      end
   end

   assign out_valid       = s3_valid_ff;
   assign out_beat.nx     = s3_nx_ff;
   assign out_beat.ny     = s3_ny_ff;
   assign out_beat.colour = s3_colour_ff;

   // Stalled stages keep their contents
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !ready2 |=> s2_valid_ff && $stable(s2_xc_ff) && $stable(s2_ys_ff))
      else $error("stage 2 changed while stalled");

   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !out_ready |=> s3_valid_ff && $stable(s3_nx_ff) && $stable(s3_ny_ff))
      else $error("stage 3 changed while stalled");

endmodule

### hdl/prs_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_place: rounding, window test and frame address
// Stage 4 rounds half away from zero and drops pixels outside the window;
// stage 5 forms the linear address and is the output register.
// ----------------------------------------------------------------------------
module prs_place (
   input  logic                          clock,
   input  logic                          reset,
   input  prs_pkg::cfg_type              cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  prs_pkg::rot_beat_type         in_beat,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [prs_pkg::DIM_W-1:0]     rsp_dest_x,
   output logic [prs_pkg::DIM_W-1:0]     rsp_dest_y,
   output logic [prs_pkg::ADDR_W-1:0]    rsp_dest_address,
   output logic [prs_pkg::COLOUR_W-1:0]  rsp_out_colour
);
   import prs_pkg::*;

   logic [CFG_DIM_W-1:0]      ww_eff, wh_eff;
   logic signed [SUM_W-1:0]   tx, ty;
   logic signed [SUM_W-1:0]   shx, shy;
   logic signed [COORD_W-1:0] rx, ry;
   logic                      in_window;

   logic                      s4_valid_ff, s4_valid_in;
   logic [DIM_W-1:0]          s4_x_ff, s4_y_ff;
   logic [COLOUR_W-1:0]       s4_colour_ff;

   logic                      s5_valid_ff;
   logic [DIM_W-1:0]          s5_x_ff, s5_y_ff;
   logic [ADDR_W-1:0]         s5_addr_ff, s5_addr_in;
   logic [COLOUR_W-1:0]       s5_colour_ff;

   logic ready4, ready5;

   assign ww_eff = (int'(cfg.window_width) > MAX_DIM) ? CFG_DIM_W'(MAX_DIM)
                                                       : cfg.window_width;
   assign wh_eff = (int'(cfg.window_height) > MAX_DIM) ? CFG_DIM_W'(MAX_DIM)
                                                        : cfg.window_height;

   // Half away from zero: add a half, minus one more below zero, then floor
   assign tx  = in_beat.nx + (SUM_W'(1) <<< TRIG_FRAC_BITS) - SUM_W'(in_beat.nx[SUM_W-1]);
   assign ty  = in_beat.ny + (SUM_W'(1) <<< TRIG_FRAC_BITS) - SUM_W'(in_beat.ny[SUM_W-1]);
   assign shx = tx >>> (TRIG_FRAC_BITS + 1);
   assign shy = ty >>> (TRIG_FRAC_BITS + 1);
   assign rx  = shx[COORD_W-1:0];
   assign ry  = shy[COORD_W-1:0];

   assign in_window = !rx[COORD_W-1] && !ry[COORD_W-1]
                   && (rx[COORD_W-2:0] < (COORD_W - 1)'(ww_eff))
                   && (ry[COORD_W-2:0] < (COORD_W - 1)'(wh_eff));

   assign ready5      = !s5_valid_ff || rsp_ready;
   assign ready4      = !s4_valid_ff || ready5;
   assign in_ready    = ready4;
   assign s4_valid_in = in_valid && in_window;

   assign s5_addr_in = ADDR_W'(s4_y_ff * ww_eff + (ADDR_W + 1)'(s4_x_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (ready4) begin
            s4_valid_ff <= s4_valid_in;
         end
         if (ready5) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && s4_valid_in) begin
         s4_x_ff      <= rx[DIM_W-1:0];
         s4_y_ff      <= ry[DIM_W-1:0];
         s4_colour_ff <= in_beat.colour;
      end
      if (ready5 && s4_valid_ff) begin
         s5_x_ff      <= s4_x_ff;
         s5_y_ff      <= s4_y_ff;
         s5_addr_ff   <= s5_addr_in;
         s5_colour_ff <= s4_colour_ff;
      end
   end

   assign rsp_valid        = s5_valid_ff;
   assign rsp_dest_x       = s5_x_ff;
   assign rsp_dest_y       = s5_y_ff;
   assign rsp_dest_address = s5_addr_ff;
   assign rsp_out_colour   = s5_colour_ff;

   // Only pixels inside the clamped window leave the block
   a_x_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CFG_DIM_W'(rsp_dest_x) < ww_eff))
      else $error("dest_x outside window");

   a_y_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CFG_DIM_W'(rsp_dest_y) < wh_eff))
      else $error("dest_y outside window");

endmodule

### hdl/pixel_rotation_scatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_rotation_scatter: forward-mapped nearest-neighbor image rotation
// Rotates each source pixel centre about the image centre by a whole-degree
// angle and scatters it to a destination frame address, dropping pixels
// that land outside the window.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Beat contents
//  req_      in         req_valid/req_ready  src_x, src_y, colour
//  rsp_      out        rsp_valid/rsp_ready  dest_x, dest_y, dest_address, out_colour
//  csr_      in         csr_valid/csr_ready  index, data (11 bits, angle uses 9)
//
//  One pixel per clock sustained while rsp_ready stays high; five register stages
//  from an accepted req beat to rsp_valid. Trig lookup and deltas fill stage 1,
//  the four rotation multiplies share stage 2, the sums stage 3, rounding and the
//  window test stage 4 and the address multiply stage 5, which sets the depth.
//  Reset clears every stage's valid bit and loads the register defaults.
//  A stall at rsp_ready holds each full stage in place and backs up stage by
//  stage to req_ready; pixels that fall outside the window vanish at stage 4.
//  csr_ready is always high.
//
module pixel_rotation_scatter (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [prs_pkg::DIM_W-1:0]          req_src_x,
   input  logic [prs_pkg::DIM_W-1:0]          req_src_y,
   input  logic [prs_pkg::COLOUR_W-1:0]       req_colour,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [prs_pkg::DIM_W-1:0]          rsp_dest_x,
   output logic [prs_pkg::DIM_W-1:0]          rsp_dest_y,
   output logic [prs_pkg::ADDR_W-1:0]         rsp_dest_address,
   output logic [prs_pkg::COLOUR_W-1:0]       rsp_out_colour,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [prs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0]     csr_data
);
   import prs_pkg::*;

   // Register reset values
   localparam logic [CFG_DIM_W-1:0] IMAGE_WIDTH_RST   = CFG_DIM_W'(256);
   localparam logic [CFG_DIM_W-1:0] IMAGE_HEIGHT_RST  = CFG_DIM_W'(256);
   localparam logic [CFG_DIM_W-1:0] WINDOW_WIDTH_RST  = CFG_DIM_W'(640);
   localparam logic [CFG_DIM_W-1:0] WINDOW_HEIGHT_RST = CFG_DIM_W'(480);
   localparam logic [ANGLE_W-1:0]   ANGLE_RST         = '0;

   cfg_type      cfg_ff, cfg_in;
   logic         rot_valid, rot_ready;
   rot_beat_type rot_beat;

   // Register file: always writable, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   cfg_in.image_width   = csr_data;
            CSR_IMAGE_HEIGHT:  cfg_in.image_height  = csr_data;
            CSR_WINDOW_WIDTH:  cfg_in.window_width  = csr_data;
            CSR_WINDOW_HEIGHT: cfg_in.window_height = csr_data;
            CSR_ANGLE_DEGREES: cfg_in.angle_degrees = csr_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= IMAGE_WIDTH_RST;
         cfg_ff.image_height  <= IMAGE_HEIGHT_RST;
         cfg_ff.window_width  <= WINDOW_WIDTH_RST;
         cfg_ff.window_height <= WINDOW_HEIGHT_RST;
         cfg_ff.angle_degrees <= ANGLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Stages 1-3: deltas, products, numerators
   prs_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .src_x     (req_src_x),
      .src_y     (req_src_y),
      .colour    (req_colour),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_beat  (rot_beat)
   );

   // Stages 4-5: round, window drop, address, output register
   prs_place u_place (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .in_valid         (rot_valid),
      .in_ready         (rot_ready),
      .in_beat          (rot_beat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dest_x       (rsp_dest_x),
      .rsp_dest_y       (rsp_dest_y),
      .rsp_dest_address (rsp_dest_address),
      .rsp_out_colour   (rsp_out_colour)
   );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_rotation_scatter
// Streams source pixels through the rotator under several register settings
// and checks every placed pixel against a bit-accurate predictor or typed value.
// A short table of directed beats covers the corners first. Randomized
// phases with random stalls on both channels follow.
// ----------------------------------------------------------------------------
module tb;
   import prs_pkg::*;

   // Handshake pacing
   localparam int IDLE_PCT        = 32;
   localparam int NO_IDLE_PHASE   = 2;
   // Five pipeline stages; a dropped pixel can still be in flight after the queue empties
   localparam int DRAIN_CYCLES    = 12;
   localparam int TAIL_CYCLES     = 20;
   localparam int WATCHDOG_LIMIT  = 2000;

   // Random part
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 118;
   localparam int MIN_LANDED      = 60;
   localparam int IN_IMAGE_PCT    = 75;

   // Sine series, evaluated in Q2.30
   localparam int SERIES_FRAC     = 30;

   // Register defaults after reset
   localparam int RESET_IMAGE_DIM   = 256;
   localparam int RESET_WINDOW_W    = 640;
   localparam int RESET_WINDOW_H    = 480;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_TOP = '1;
   localparam logic [CFG_DIM_W-1:0]   EXTENT_TOP    = '1;
   localparam logic [CFG_DIM_W-1:0]   EXTENT_FULL   = CFG_DIM_W'(MAX_DIM);
   localparam logic [CFG_DIM_W-1:0]   EXTENT_ONE    = CFG_DIM_W'(1);

   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_LANDS,
      CHECK_DROPS
   } check_kind_type;

   typedef enum logic {
      ROW_PIXEL,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      logic [DIM_W-1:0]    dest_x;
      logic [DIM_W-1:0]    dest_y;
      logic [ADDR_W-1:0]   dest_address;
      logic [COLOUR_W-1:0] colour;
   } placement_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
      logic [DIM_W-1:0]       src_x;
      logic [DIM_W-1:0]       src_y;
      logic [COLOUR_W-1:0]    colour;
      check_kind_type         check;
      placement_type          typed;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT ports, inputs driven to known values from time zero
   // ------------------------------------------------------------------------
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [DIM_W-1:0]       req_src_x = '0;
   logic [DIM_W-1:0]       req_src_y = '0;
   logic [COLOUR_W-1:0]    req_colour = '0;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [DIM_W-1:0]       rsp_dest_x;
   logic [DIM_W-1:0]       rsp_dest_y;
   logic [ADDR_W-1:0]      rsp_dest_address;
   logic [COLOUR_W-1:0]    rsp_out_colour;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   pixel_rotation_scatter dut (.*);

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   // Shadow copy of the register file, updated on each accepted csr beat
   logic [CFG_DIM_W-1:0] cfg_img_w;
   logic [CFG_DIM_W-1:0] cfg_img_h;
   logic [CFG_DIM_W-1:0] cfg_win_w;
   logic [CFG_DIM_W-1:0] cfg_win_h;
   logic [ANGLE_W-1:0]   cfg_angle;

   longint         quarter_sine [0:DEG_90];
   placement_type  pending_placements [$];

   // How the pixel beat currently on req_ is to be checked
   check_kind_type pending_check = CHECK_MODEL;
   placement_type  pending_typed = '0;

   bit          no_idle    = 1'b0;
   bit          hold_ready = 1'b0;
   int          mismatches    = 0;
   int          landed_count  = 0;
   int          quiet_cycles  = 0;

   // ------------------------------------------------------------------------
   // Directed table: typed expectations only where they are obvious
   // ------------------------------------------------------------------------
   function automatic stim_row_type pixel_row(input logic [DIM_W-1:0]    sx,
                                              input logic [DIM_W-1:0]    sy,
                                              input logic [COLOUR_W-1:0] col,
                                              input check_kind_type      chk,
                                              input logic [DIM_W-1:0]    dx,
                                              input logic [DIM_W-1:0]    dy,
                                              input logic [ADDR_W-1:0]   addr);
      stim_row_type r;
      r                    = '0;
      r.kind               = ROW_PIXEL;
      r.src_x              = sx;
      r.src_y              = sy;
      r.colour             = col;
      r.check              = chk;
      r.typed.dest_x       = dx;
      r.typed.dest_y       = dy;
      r.typed.dest_address = addr;
      r.typed.colour       = col;
      return r;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0]  value);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.data  = value;
      r.check = CHECK_MODEL;
      return r;
   endfunction

   localparam int NUM_ROWS = 35;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // Reset settings: angle 0 is the identity map into a 640x480 window
      pixel_row(0, 0, '0, CHECK_LANDS, 0, 0, 0),
      pixel_row(639, 479, '1, CHECK_LANDS, 639, 479, 307199),
      pixel_row(640, 0, 32'hA5A5_A5A5, CHECK_DROPS, 0, 0, 0),
      pixel_row(0, 480, 32'h5A5A_5A5A, CHECK_DROPS, 0, 0, 0),
      pixel_row(1023, 1023, 32'h0123_4567, CHECK_DROPS, 0, 0, 0),
      // Half turn mirrors the 256x256 image about its centre
      reg_row(CSR_ANGLE_DEGREES, 180),
      pixel_row(0, 0, 32'hDEAD_BEEF, CHECK_LANDS, 255, 255, 163455),
      pixel_row(256, 0, 32'h8000_0001, CHECK_DROPS, 0, 0, 0),
      reg_row(CSR_ANGLE_DEGREES, 90),
      pixel_row(10, 3, 32'h0F0F_0F0F, CHECK_MODEL, 0, 0, 0),
      reg_row(CSR_ANGLE_DEGREES, 45),
      pixel_row(128, 0, 32'hF0F0_F0F0, CHECK_MODEL, 0, 0, 0),
      pixel_row(200, 100, 32'h1234_5678, CHECK_MODEL, 0, 0, 0),
      reg_row(CSR_ANGLE_DEGREES, 359),
      pixel_row(300, 20, 32'h9ABC_DEF0, CHECK_MODEL, 0, 0, 0),
      // All data bits set: angle keeps its low 9 bits and wraps past 359
      reg_row(CSR_ANGLE_DEGREES, EXTENT_TOP),
      pixel_row(100, 200, 32'h7FFF_FFFF, CHECK_MODEL, 0, 0, 0),
      // Oversized window clamps to the full grid; corner hits the top address
      reg_row(CSR_ANGLE_DEGREES, 0),
      reg_row(CSR_WINDOW_WIDTH, EXTENT_TOP),
      reg_row(CSR_WINDOW_HEIGHT, EXTENT_TOP),
      pixel_row(1023, 1023, '1, CHECK_LANDS, 1023, 1023, 20'hFFFFF),
      // Image extents outside the legal range are used as written
      reg_row(CSR_IMAGE_WIDTH, 0),
      reg_row(CSR_IMAGE_HEIGHT, EXTENT_TOP),
      reg_row(CSR_ANGLE_DEGREES, 30),
      pixel_row(5, 1000, 32'h0000_FFFF, CHECK_MODEL, 0, 0, 0),
      // Write to an unmapped index must leave every register alone
      reg_row(CSR_SPARE_TOP, 11'h555),
      pixel_row(700, 20, 32'hFFFF_0000, CHECK_MODEL, 0, 0, 0),
      reg_row(CSR_IMAGE_WIDTH, EXTENT_FULL),
      reg_row(CSR_IMAGE_HEIGHT, EXTENT_FULL),
      pixel_row(1023, 0, 32'h3C3C_3C3C, CHECK_MODEL, 0, 0, 0),
      // Smallest window: one pixel
      reg_row(CSR_ANGLE_DEGREES, 0),
      reg_row(CSR_WINDOW_WIDTH, 1),
      reg_row(CSR_WINDOW_HEIGHT, 1),
      pixel_row(0, 0, 32'hC3C3_C3C3, CHECK_LANDS, 0, 0, 0),
      pixel_row(1, 0, 32'h6969_6969, CHECK_DROPS, 0, 0, 0)
   };

   // ------------------------------------------------------------------------
   // Rotation predictor
   // ------------------------------------------------------------------------
   // Build sin(k deg), k = 0..90, in Q1.14 from a truncated Q2.30 series
   initial begin
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      for (int k = 0; k <= DEG_90; k++) begin
         x    = (longint'(k) * PI_Q30 + DEG_90) / DEG_180;
         x2   = (x * x) >> SERIES_FRAC;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * x2) >> SERIES_FRAC) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         // Round half up to the table fraction
         quarter_sine[k] = (acc + (longint'(1) << (SERIES_FRAC - 1 - TRIG_FRAC_BITS)))
                           >>> (SERIES_FRAC - TRIG_FRAC_BITS);
      end
   end

   // Fold any angle onto the quarter wave
   function automatic longint sine_of_degrees(input int unsigned deg);
      int unsigned a;
      a = deg % DEG_360;
      if (a <= DEG_90) begin
         return quarter_sine[a];
      end
      if (a <= DEG_180) begin
         return quarter_sine[DEG_180 - a];
      end
      if (a <= DEG_270) begin
         return -quarter_sine[a - DEG_180];
      end
      return -quarter_sine[DEG_360 - a];
   endfunction

   // Divide by 2^(F+1), rounding half away from zero
   function automatic longint round_half_away(input longint n);
      longint half;
      half = longint'(1) << TRIG_FRAC_BITS;
      if (n >= 0) begin
         return (n + half) >>> (TRIG_FRAC_BITS + 1);
      end
      return -((-n + half) >>> (TRIG_FRAC_BITS + 1));
   endfunction

   // Place one source pixel; returns 0 when it lands outside the window
   function automatic bit rotate_pixel(input  logic [DIM_W-1:0]    sx,
                                       input  logic [DIM_W-1:0]    sy,
                                       input  logic [COLOUR_W-1:0] col,
                                       output placement_type       p);
      longint s, c, dx, dy, nx, ny, rx, ry, ww, wh, iw, ih;
      s  = sine_of_degrees(int'(cfg_angle));
      c  = sine_of_degrees(int'(cfg_angle) + DEG_90);
      iw = longint'(cfg_img_w);
      ih = longint'(cfg_img_h);
      ww = (cfg_win_w > MAX_DIM) ? longint'(MAX_DIM) : longint'(cfg_win_w);
      wh = (cfg_win_h > MAX_DIM) ? longint'(MAX_DIM) : longint'(cfg_win_h);
      // Half-pixel offsets of the pixel centre from the image centre
      dx = 2 * longint'(sx) + 1 - iw;
      dy = 2 * longint'(sy) + 1 - ih;
      nx = dx * c - dy * s + (iw - 1) * (longint'(1) << TRIG_FRAC_BITS);
      ny = dx * s + dy * c + (ih - 1) * (longint'(1) << TRIG_FRAC_BITS);
      rx = round_half_away(nx);
      ry = round_half_away(ny);
      p  = '0;
      if (rx < 0 || rx >= ww || ry < 0 || ry >= wh) begin
         return 1'b0;
      end
      p.dest_x       = DIM_W'(rx);
      p.dest_y       = DIM_W'(ry);
      p.dest_address = ADDR_W'(ry * ww + rx);
      p.colour       = col;
      return 1'b1;
   endfunction

   // Pick an extent: mostly legal sizes, with the edges and illegal ones mixed in
   function automatic logic [CFG_DIM_W-1:0] pick_extent();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) begin
         return EXTENT_ONE;
      end
      if (roll < 12) begin
         return EXTENT_FULL;
      end
      if (roll < 18) begin
         return CFG_DIM_W'($urandom_range(EXTENT_TOP, MAX_DIM + 1));
      end
      if (roll < 21) begin
         return '0;
      end
      return CFG_DIM_W'($urandom_range(MAX_DIM, 16));
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Clock, stall generator and watchdog
   // ------------------------------------------------------------------------
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result channel at random; hold ready high while draining
   always @(negedge clock) begin
      if (hold_ready || no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Abort when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: track registers, predict on each pixel beat, check each result
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      placement_type guess;
      if (reset) begin
         cfg_img_w = CFG_DIM_W'(RESET_IMAGE_DIM);
         cfg_img_h = CFG_DIM_W'(RESET_IMAGE_DIM);
         cfg_win_w = CFG_DIM_W'(RESET_WINDOW_W);
         cfg_win_h = CFG_DIM_W'(RESET_WINDOW_H);
         cfg_angle = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   cfg_img_w = csr_data;
               CSR_IMAGE_HEIGHT:  cfg_img_h = csr_data;
               CSR_WINDOW_WIDTH:  cfg_win_w = csr_data;
               CSR_WINDOW_HEIGHT: cfg_win_h = csr_data;
               CSR_ANGLE_DEGREES: cfg_angle = csr_data[ANGLE_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            case (pending_check)
               CHECK_LANDS: begin
                  pending_placements.push_back(pending_typed);
                  landed_count++;
               end
               CHECK_DROPS: ;
               default: begin
                  if (rotate_pixel(req_src_x, req_src_y, req_colour, guess)) begin
                     pending_placements.push_back(guess);
                     landed_count++;
                  end
               end
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            got.dest_x       = rsp_dest_x;
            got.dest_y       = rsp_dest_y;
            got.dest_address = rsp_dest_address;
            got.colour       = rsp_out_colour;
            if (pending_placements.size() == 0) begin
               report_mismatch($sformatf("unexpected result x=%0d y=%0d addr=%0d",
                                         got.dest_x, got.dest_y, got.dest_address));
            end else begin
               want = pending_placements.pop_front();
               if (got.dest_x !== want.dest_x) begin
                  report_mismatch($sformatf("dest_x got %0d want %0d",
                                            got.dest_x, want.dest_x));
               end
               if (got.dest_y !== want.dest_y) begin
                  report_mismatch($sformatf("dest_y got %0d want %0d",
                                            got.dest_y, want.dest_y));
               end
               if (got.dest_address !== want.dest_address) begin
                  report_mismatch($sformatf("dest_address got %0d want %0d",
                                            got.dest_address, want.dest_address));
               end
               if (got.colour !== want.colour) begin
                  report_mismatch($sformatf("out_colour got %h want %h",
                                            got.colour, want.colour));
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   // Offer one pixel beat and hold it until accepted
   task automatic push_pixel(input logic [DIM_W-1:0]    sx,
                             input logic [DIM_W-1:0]    sy,
                             input logic [COLOUR_W-1:0] col,
                             input check_kind_type      chk,
                             input placement_type       typed);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      pending_check = chk;
      pending_typed = typed;
      req_valid  <= 1'b1;
      req_src_x  <= sx;
      req_src_y  <= sy;
      req_colour <= col;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0]  value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait for every placed pixel, then flush dropped ones
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) begin
         @(negedge clock);
      end
      hold_ready = 1'b1;
      repeat (DRAIN_CYCLES) @(negedge clock);
      hold_ready = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      stim_row_type          row;
      logic [CFG_DIM_W-1:0]  ext_w;
      logic [CFG_DIM_W-1:0]  ext_h;
      logic [CSR_DATA_W-1:0] angle_word;
      int unsigned           span_x;
      int unsigned           span_y;
      logic [DIM_W-1:0]      sx;
      logic [DIM_W-1:0]      sy;

      // Hold reset high from time zero, release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table; register rows wait for an idle pipeline
      for (int i = 0; i < NUM_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            drain_pipeline();
            write_register(row.index, row.data);
         end else begin
            push_pixel(row.src_x, row.src_y, row.colour, row.check, row.typed);
         end
      end

      // Random phases, each under a fresh register setting
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_pipeline();
         ext_w = pick_extent();
         ext_h = pick_extent();
         write_register(CSR_IMAGE_WIDTH, ext_w);
         write_register(CSR_IMAGE_HEIGHT, ext_h);
         write_register(CSR_WINDOW_WIDTH, pick_extent());
         write_register(CSR_WINDOW_HEIGHT, pick_extent());
         // Fill the unused data bits too; angles past 359 now and then
         angle_word = CSR_DATA_W'($urandom);
         if ($urandom_range(99) < 10) begin
            angle_word[ANGLE_W-1:0] = ANGLE_W'($urandom_range(2 ** ANGLE_W - 1, DEG_360));
         end else begin
            angle_word[ANGLE_W-1:0] = ANGLE_W'($urandom_range(DEG_360 - 1, 0));
         end
         write_register(CSR_ANGLE_DEGREES, angle_word);
         if ($urandom_range(3) == 0) begin
            write_register(CSR_INDEX_W'($urandom_range(CSR_SPARE_TOP, CSR_ANGLE_DEGREES + 1)),
                           CSR_DATA_W'($urandom));
         end

         // Most pixels come from inside the image so they tend to land
         span_x = (ext_w == 0) ? 1 : (ext_w > MAX_DIM) ? MAX_DIM : ext_w;
         span_y = (ext_h == 0) ? 1 : (ext_h > MAX_DIM) ? MAX_DIM : ext_h;
         no_idle = (phase == NO_IDLE_PHASE);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(99) < IN_IMAGE_PCT) begin
               sx = DIM_W'($urandom_range(span_x - 1, 0));
               sy = DIM_W'($urandom_range(span_y - 1, 0));
            end else begin
               sx = DIM_W'($urandom);
               sy = DIM_W'($urandom);
            end
            push_pixel(sx, sy, $urandom, CHECK_MODEL, '0);
         end
         no_idle = 1'b0;
      end

      // Top up with an identity map over the full grid if few pixels landed
      if (landed_count < MIN_LANDED) begin
         drain_pipeline();
         write_register(CSR_ANGLE_DEGREES, '0);
         write_register(CSR_WINDOW_WIDTH, EXTENT_FULL);
         write_register(CSR_WINDOW_HEIGHT, EXTENT_FULL);
         while (landed_count < MIN_LANDED) begin
            push_pixel(DIM_W'($urandom), DIM_W'($urandom), $urandom, CHECK_MODEL, '0);
         end
      end

      // Drop valid, wait out the remaining results, then a quiet tail
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_placements.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### sim.f
hdl/prs_pkg.sv
hdl/prs_trig.sv
hdl/prs_rotate.sv
hdl/prs_place.sv
hdl/pixel_rotation_scatter.sv
verif/tb.sv
